// ===== design/tmq_pkg.sv =====
// Package for the timer alarm queue: queue sizing, command and result codes,
// request and result structs, and the controller/datapath control structs.
// Depends on nothing; every other file of the block imports it.
package tmq_pkg;

  // Queue sizing.
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Command codes of an input request.
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_PUSH = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  // Result kind codes.
  localparam logic [2:0] KIND_ACCEPT = 3'd0;
  localparam logic [2:0] KIND_FULL   = 3'd1;
  localparam logic [2:0] KIND_FIRED  = 3'd2;
  localparam logic [2:0] KIND_IDLE   = 3'd3;
  localparam logic [2:0] KIND_STOP   = 3'd4;

  // One input request.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] delay;
    logic [7:0]  callback_tag;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] fired_tag;
    logic [4:0] pending_count;
    logic       last_of_run;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // capture the accepted request
    logic dispatch;  // execute push, stop or the time advance of a tick
    logic scan_step; // examine one stored alarm
    logic remove;    // pop the best due alarm, forward any held result
    logic finish;    // send the final result of the request
  } tmq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] item_cmd;
    logic       scan_end;
    logic       found;
    logic       pend_valid;
    logic       out_free;
  } tmq_stat_t;

endpackage

// ===== design/timer_alarm_queue_unit.sv =====
// Top level of the timer alarm queue: controller plus datapath.
// Depends on tmq_pkg, tmq_ctrl and tmq_datapath.
//
//   Channel   Direction  Handshake               Payload
//   in_       input      in_valid / in_ready     in_item_t  (cmd, delay, callback_tag)
//   out_      output     out_valid / out_ready   out_item_t (kind, fired_tag,
//                                                pending_count, last_of_run)
//
// A push or stop loads its result from the finish state that follows dispatch; an
// unused command is dropped after dispatch with no result. A tick dispatches,
// then runs one search over the stored alarms per fired alarm plus a final one,
// with a pop after each search that finds a due alarm, then loads its final result.
// Synchronous active-low reset empties the queue, clears time and the stop flag.
// A stalled output delays the next pop and the final result; a new request is
// taken once the previous one has loaded its final result, even while it waits.
module timer_alarm_queue_unit
  import tmq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  tmq_cmd_t  cmd;
  tmq_stat_t stat;

  // Sequencer.
  tmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Queue storage and search.
  tmq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/tmq_ctrl.sv =====
// Controller state machine of the timer alarm queue.
// Sequences dispatch, scan, pop and result delivery; uses tmq_pkg.
module tmq_ctrl
  import tmq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tmq_stat_t stat,
  output tmq_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_REMOVE   = 3'd3;
  localparam logic [2:0] ST_FINISH   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.dispatch = 1'b1;
        case (stat.item_cmd)
          CMD_TICK: state_nxt = ST_SCAN;
          CMD_PUSH: state_nxt = ST_FINISH;
          CMD_STOP: state_nxt = ST_FINISH;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (!stat.scan_end) begin
          cmd.scan_step = 1'b1;
        end else if (stat.found) begin
          state_nxt = ST_REMOVE;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_REMOVE: begin
        // A held fired result must leave before the next one replaces it.
        if (!stat.pend_valid || stat.out_free) begin
          cmd.remove = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/tmq_datapath.sv =====
// Datapath of the timer alarm queue: time counter, packed alarm slots,
// serial due-time search, held fired result and output register; uses tmq_pkg.
module tmq_datapath
  import tmq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  tmq_cmd_t  cmd,
  output tmq_stat_t stat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Captured request.
  in_item_t         item_r;

  // Queue state: alarms are packed in slots below used_r, in insertion order.
  logic [31:0]      time_r;
  logic             stopped_r;
  logic [CNT_W-1:0] used_r;
  logic [31:0]      due_r [QUEUE_DEPTH];
  logic [7:0]       tag_r [QUEUE_DEPTH];

  // Search state.
  logic [CNT_W-1:0] scan_r;
  logic             found_r;
  logic [IDX_W-1:0] best_r;
  logic [31:0]      best_d_r;

  // Result of the current request and the held fired result.
  logic [2:0]       res_kind_r;
  logic             pend_valid_r;
  logic [7:0]       pend_tag_r;
  logic [CNT_W-1:0] pend_count_r;

  // Output register.
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             full;
  logic             out_free;
  logic [IDX_W-1:0] scan_idx;
  logic [31:0]      due_dist;
  logic             is_due;
  logic             is_better;

  assign full     = (used_r >= CNT_W'(QUEUE_DEPTH));
  assign out_free = !out_valid_r || out_ready;
  assign scan_idx = scan_r[IDX_W-1:0];

  // Wrap-safe distance of the scanned alarm; due when it is zero or negative.
  assign due_dist  = due_r[scan_idx] - time_r;
  assign is_due    = due_dist[31] || (due_dist == 32'd0);
  assign is_better = !found_r || ($signed(due_dist) < $signed(best_d_r));

  assign stat.item_cmd   = item_r.cmd;
  assign stat.scan_end   = (scan_r >= used_r) || stopped_r;
  assign stat.found      = found_r;
  assign stat.pend_valid = pend_valid_r;
  assign stat.out_free   = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
  end

  // Time counter, stop flag, fill count and result kind.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r     <= 32'd0;
      stopped_r  <= 1'b0;
      used_r     <= '0;
      res_kind_r <= KIND_IDLE;
    end else if (cmd.dispatch) begin
      case (item_r.cmd)
        CMD_PUSH: begin
          if (full) begin
            res_kind_r <= KIND_FULL;
          end else begin
            used_r     <= used_r + CNT_W'(1);
            res_kind_r <= KIND_ACCEPT;
          end
        end
        CMD_STOP: begin
          stopped_r  <= 1'b1;
          res_kind_r <= KIND_STOP;
        end
        CMD_TICK: begin
          time_r     <= time_r + 32'd1;
          res_kind_r <= KIND_IDLE;
        end
        default: res_kind_r <= KIND_IDLE;
      endcase
    end else if (cmd.remove) begin
      used_r <= used_r - CNT_W'(1);
    end
  end

  // Alarm slots: a pop shifts the later slots down, a push writes at the end.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (cmd.remove && (IDX_W'(i) >= best_r)) begin
        if (i < QUEUE_DEPTH - 1) begin
          due_r[i] <= due_r[(i + 1) % QUEUE_DEPTH];
          tag_r[i] <= tag_r[(i + 1) % QUEUE_DEPTH];
        end
      end else if (cmd.dispatch && (item_r.cmd == CMD_PUSH) && !full &&
                   (IDX_W'(i) == used_r[IDX_W-1:0])) begin
        due_r[i] <= time_r + {16'd0, item_r.delay};
        tag_r[i] <= item_r.callback_tag;
      end
    end
  end

  // Serial search for the earliest due alarm, lowest slot on a tie.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= '0;
      found_r <= 1'b0;
    end else if (cmd.dispatch || cmd.remove) begin
      scan_r  <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_r + CNT_W'(1);
      if (is_due && is_better) begin
        found_r  <= 1'b1;
        best_r   <= scan_idx;
        best_d_r <= due_dist;
      end
    end
  end

  // Held fired result: its last flag is known only after the next search.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.remove) begin
      pend_valid_r <= 1'b1;
      pend_tag_r   <= tag_r[best_r];
      pend_count_r <= used_r - CNT_W'(1);
    end else if (cmd.finish) begin
      pend_valid_r <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.remove && pend_valid_r) begin
        out_valid_r                <= 1'b1;
        out_data_r.kind            <= KIND_FIRED;
        out_data_r.fired_tag       <= pend_tag_r;
        out_data_r.pending_count   <= 5'(pend_count_r);
        out_data_r.last_of_run     <= 1'b0;
      end else if (cmd.finish) begin
        out_valid_r            <= 1'b1;
        out_data_r.last_of_run <= 1'b1;
        if (pend_valid_r) begin
          out_data_r.kind          <= KIND_FIRED;
          out_data_r.fired_tag     <= pend_tag_r;
          out_data_r.pending_count <= 5'(pend_count_r);
        end else begin
          out_data_r.kind          <= res_kind_r;
          out_data_r.fired_tag     <= 8'd0;
          out_data_r.pending_count <= 5'(used_r);
        end
      end
    end
  end

endmodule
